/* hdl/rcs_pkg.sv */
`default_nettype none

package rcs_pkg;

    localparam int MAX_COLS_DEF  = 1024;
    localparam int MAX_ROWS_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 6;
    localparam int Q_DEPTH       = 2;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;
    localparam int ROW_W      = 10;
    localparam int CENT_W     = 16;
    localparam int EDGE_ROW_W = 11;

    localparam logic [CFG_DATA_W-1:0] FRAME_COLS_RST = 11'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST = 11'd480;
    localparam logic [7:0]            PIX_LIT        = 8'd255;
    localparam logic signed [EDGE_ROW_W-1:0] ROW_NONE = -11'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COLS = 4'd0,
        CFG_FRAME_ROWS = 4'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic int cnt_width(input int max_len);
        return $clog2(max_len + 1);
    endfunction

    function automatic int sum_width(input int max_cols);
        return $clog2(max_cols * (max_cols - 1) / 2 + 1);
    endfunction

    function automatic int job_width(input int max_cols);
        return ROW_W + 2 * EDGE_ROW_W + 2 + cnt_width(max_cols) + sum_width(max_cols);
    endfunction

endpackage

`default_nettype wire

/* hdl/rcs_if.sv */
`default_nettype none

interface rcs_pix_if;
    import rcs_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface rcs_res_if;
    import rcs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ROW_W-1:0]             row_index;
    logic [CENT_W-1:0]            row_centroid;
    logic                         row_lit;
    logic                         scan_stopped;
    logic signed [EDGE_ROW_W-1:0] first_lit_row;
    logic signed [EDGE_ROW_W-1:0] last_lit_row;
    logic                         frame_done;

    modport source (
        output valid, output row_index, output row_centroid, output row_lit,
        output scan_stopped, output first_lit_row, output last_lit_row,
        output frame_done, input ready
    );
    modport sink (
        input valid, input row_index, input row_centroid, input row_lit,
        input scan_stopped, input first_lit_row, input last_lit_row,
        input frame_done, output ready
    );
endinterface

interface rcs_cfg_if;
    import rcs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/rcs_front.sv */
`default_nettype none

module rcs_front #(
    parameter int MAX_COLS = rcs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = rcs_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rcs_pix_if.sink                         pix,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]  frame_cols,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]  frame_rows,
    input  rcs_pkg::q_stat_t                q_stat,
    output logic                            push,
    output logic [rcs_pkg::job_width(MAX_COLS)-1:0] push_data
);
    import rcs_pkg::*;

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CNTW = cnt_width(MAX_COLS);
    localparam int SW   = sum_width(MAX_COLS);
    localparam int RCW  = cnt_width(MAX_ROWS);
    localparam int LW   = (CNTW > CFG_DATA_W) ? CNTW : CFG_DATA_W;
    localparam int RLW  = (RCW > CFG_DATA_W) ? RCW : CFG_DATA_W;

    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]   first_reg, first_next;
    logic            first_vld_reg, first_vld_next;
    logic [RW-1:0]   last_reg, last_next;
    logic            last_vld_reg, last_vld_next;
    logic            stop_reg, stop_next;

    logic            accept;
    logic            lit_px;
    logic [SW-1:0]   sum_add;
    logic [CNTW-1:0] cnt_add;
    logic [LW-1:0]   cols_cfg, cols_eff;
    logic [RLW-1:0]  rows_cfg, rows_eff;
    logic            row_end;
    logic            frame_end;
    logic            row_lit;
    logic [RW-1:0]   first_end, last_end;
    logic            first_vld_end, last_vld_end, stop_end;
    logic [EDGE_ROW_W-1:0] first_out, last_out;

    assign pix.ready = !q_stat.full;
    assign accept    = pix.valid && pix.ready;

    always_comb
    begin
        cols_cfg = LW'(frame_cols);
        if (cols_cfg == '0)
        begin
            cols_eff = LW'(1);
        end
        else if (cols_cfg > LW'(MAX_COLS))
        begin
            cols_eff = LW'(MAX_COLS);
        end
        else
        begin
            cols_eff = cols_cfg;
        end

        rows_cfg = RLW'(frame_rows);
        if (rows_cfg == '0)
        begin
            rows_eff = RLW'(1);
        end
        else if (rows_cfg > RLW'(MAX_ROWS))
        begin
            rows_eff = RLW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_cfg;
        end
    end

    always_comb
    begin
        lit_px    = !stop_reg && (pix.pixel == PIX_LIT);
        sum_add   = sum_reg + (lit_px ? SW'(col_reg) : SW'(0));
        cnt_add   = cnt_reg + CNTW'(lit_px);
        row_end   = (LW'(col_reg) + LW'(1)) >= cols_eff;
        frame_end = (RLW'(row_reg) + RLW'(1)) >= rows_eff;
        row_lit   = cnt_add != '0;

        first_end     = first_reg;
        first_vld_end = first_vld_reg;
        last_end      = last_reg;
        last_vld_end  = last_vld_reg;
        stop_end      = stop_reg;
        if (!stop_reg)
        begin
            if (row_lit)
            begin
                if (!first_vld_reg)
                begin
                    first_end     = row_reg;
                    first_vld_end = 1'b1;
                end
                else
                begin
                    last_end     = row_reg;
                    last_vld_end = 1'b1;
                end
            end
            else if (last_vld_reg)
            begin
                stop_end = 1'b1;
            end
        end

        first_out = first_vld_end ? EDGE_ROW_W'(first_end) : ROW_NONE;
        last_out  = last_vld_end ? EDGE_ROW_W'(last_end) : ROW_NONE;
    end

    assign push      = accept && row_end;
    assign push_data = {ROW_W'(row_reg), first_out, last_out, stop_end, frame_end,
                        cnt_add, sum_add};

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        first_vld_next = first_vld_reg;
        last_next      = last_reg;
        last_vld_next  = last_vld_reg;
        stop_next      = stop_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                sum_next = '0;
                cnt_next = '0;
                if (frame_end)
                begin
                    row_next       = '0;
                    first_vld_next = 1'b0;
                    last_vld_next  = 1'b0;
                    stop_next      = 1'b0;
                end
                else
                begin
                    row_next       = row_reg + RW'(1);
                    first_next     = first_end;
                    first_vld_next = first_vld_end;
                    last_next      = last_end;
                    last_vld_next  = last_vld_end;
                    stop_next      = stop_end;
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
                sum_next = sum_add;
                cnt_next = cnt_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            first_reg     <= '0;
            first_vld_reg <= 1'b0;
            last_reg      <= '0;
            last_vld_reg  <= 1'b0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            first_vld_reg <= first_vld_next;
            last_reg      <= last_next;
            last_vld_reg  <= last_vld_next;
            stop_reg      <= stop_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rcs_queue.sv */
`default_nettype none

module rcs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rcs_pkg::Q_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output rcs_pkg::q_stat_t stat
);
    import rcs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign stat.full  = fill_reg == NW'(DEPTH);
    assign stat.empty = fill_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        fill_next = fill_reg + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/rcs_back.sv */
`default_nettype none

module rcs_back #(
    parameter int MAX_COLS  = rcs_pkg::MAX_COLS_DEF,
    parameter int FRAC_BITS = rcs_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  rcs_pkg::q_stat_t                        q_stat,
    input  logic [rcs_pkg::job_width(MAX_COLS)-1:0] q_data,
    output logic                                    pop,
    rcs_res_if.source                               res
);
    import rcs_pkg::*;

    localparam int CNTW = cnt_width(MAX_COLS);
    localparam int SW   = sum_width(MAX_COLS);
    localparam int NW   = SW + FRAC_BITS;
    localparam int SCW  = $clog2(NW + 1);

    back_state_t state_reg, state_next;

    logic [ROW_W-1:0]      j_row;
    logic [EDGE_ROW_W-1:0] j_first, j_last;
    logic                  j_stop, j_done;
    logic [CNTW-1:0]       j_cnt;
    logic [SW-1:0]         j_sum;

    logic [SCW-1:0]        step_reg;
    logic [NW-1:0]         num_reg;
    logic [CNTW-1:0]       rem_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [EDGE_ROW_W-1:0] first_reg, last_reg;
    logic                  stop_reg, done_reg;

    logic                  out_vld_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [CENT_W-1:0]     out_cent_reg;
    logic                  out_lit_reg;
    logic                  out_stop_reg;
    logic [EDGE_ROW_W-1:0] out_first_reg, out_last_reg;
    logic                  out_done_reg;

    logic                  load_out;
    logic [CNTW:0]         rem_sh;
    logic [CNTW:0]         rem_diff;
    logic                  q_bit;

    assign {j_row, j_first, j_last, j_stop, j_done, j_cnt, j_sum} = q_data;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = (j_cnt != '0) ? BK_DIV : BK_HOLD;
                end
            end
            BK_DIV:
            begin
                if (step_reg == SCW'(1))
                begin
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (!out_vld_reg || res.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = !q_stat.empty;
            end
            BK_DIV:
            begin
            end
            BK_HOLD:
            begin
                load_out = !out_vld_reg || res.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NW-1]};
        rem_diff = rem_sh - {1'b0, cnt_reg};
        q_bit    = rem_sh >= {1'b0, cnt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            num_reg   <= NW'(j_sum) << FRAC_BITS;
            rem_reg   <= '0;
            step_reg  <= SCW'(NW);
            cnt_reg   <= j_cnt;
            row_reg   <= j_row;
            first_reg <= j_first;
            last_reg  <= j_last;
            stop_reg  <= j_stop;
            done_reg  <= j_done;
        end
        else if (state_reg == BK_DIV)
        begin
            num_reg  <= NW'({num_reg, q_bit});
            rem_reg  <= q_bit ? CNTW'(rem_diff) : CNTW'(rem_sh);
            step_reg <= step_reg - SCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg   <= row_reg;
            out_cent_reg  <= (cnt_reg != '0) ? CENT_W'(num_reg) : '0;
            out_lit_reg   <= cnt_reg != '0;
            out_stop_reg  <= stop_reg;
            out_first_reg <= first_reg;
            out_last_reg  <= last_reg;
            out_done_reg  <= done_reg;
        end
    end

    assign res.valid         = out_vld_reg;
    assign res.row_index     = out_row_reg;
    assign res.row_centroid  = out_cent_reg;
    assign res.row_lit       = out_lit_reg;
    assign res.scan_stopped  = out_stop_reg;
    assign res.first_lit_row = out_first_reg;
    assign res.last_lit_row  = out_last_reg;
    assign res.frame_done    = out_done_reg;

endmodule

`default_nettype wire

/* hdl/row_centroid_scanner.sv */
// Row centroid scanner.
// pix: one pixel byte per beat in raster order; a byte of 255 is a lit pixel.
// res: one beat per finished row with the row's mean lit column (Q10.6 by
//   default, truncated), lit and stopped flags, the frame's first and last lit
//   rows so far (-1 for none; last counts only lit rows after the first) and a flag on the frame's last row.
// cfg: writes frame_cols (index 0) and frame_rows (index 1); always ready.
//   Write only while no row result is outstanding.
// Pixels are taken at one per cycle while the job queue has room. The row-end
// beat queues a job; a restoring divider finishes it one quotient bit per
// cycle, NW quotient bits in all, where NW is the column-sum width plus
// FRAC_BITS (25 at the defaults). The divider works on one job at a time, so
// short rows are paced by it; an empty row skips the division.
// Reset: frame_cols 640, frame_rows 480, counters clear, first and last lit
// rows none, nothing stopped.
// A stalled res holds its beat; once the two-entry job queue is full pix
// drops ready until a job leaves the queue.
`default_nettype none

module row_centroid_scanner #(
    parameter int MAX_COLS  = rcs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS  = rcs_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = rcs_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rcs_pix_if.sink    pix,
    rcs_res_if.source  res,
    rcs_cfg_if.sink    cfg
);
    import rcs_pkg::*;

    localparam int JW = job_width(MAX_COLS);

    logic [CFG_DATA_W-1:0] frame_cols_reg;
    logic [CFG_DATA_W-1:0] frame_rows_reg;

    q_stat_t       q_stat;
    logic          push;
    logic [JW-1:0] push_data;
    logic          pop;
    logic [JW-1:0] pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cols_reg <= FRAME_COLS_RST;
            frame_rows_reg <= FRAME_ROWS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_FRAME_COLS:
                begin
                    frame_cols_reg <= cfg.data;
                end
                CFG_FRAME_ROWS:
                begin
                    frame_rows_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    rcs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .frame_cols (frame_cols_reg),
        .frame_rows (frame_rows_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    rcs_queue #(
        .WIDTH (JW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    rcs_back #(
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (pop_data),
        .pop    (pop),
        .res    (res)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("row job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("row job popped from an empty queue");

    a_stopped_dark: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.scan_stopped |-> !res.row_lit && (res.row_centroid == '0))
        else $error("stopped row reports a lit centroid");

    a_lit_has_first: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.row_lit |-> (res.first_lit_row != ROW_NONE))
        else $error("lit row without a first lit row");

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcs_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_PIXELS = 700;

    typedef struct packed {
        logic [ROW_W-1:0]             row_index;
        logic [CENT_W-1:0]            centroid;
        logic                         lit;
        logic                         stopped;
        logic signed [EDGE_ROW_W-1:0] first_row;
        logic signed [EDGE_ROW_W-1:0] last_row;
        logic                         frame_done;
    } row_res_t;

    typedef enum int {
        ROW_EMPTY,
        ROW_FULL,
        ROW_SPARSE,
        ROW_SINGLE,
        ROW_NOISE
    } row_kind_t;

    typedef logic [7:0] byte_q_t[$];

    class centroid_scoreboard;
        int unsigned     cols_reg;
        int unsigned     rows_reg;
        int unsigned     col_pos;
        int unsigned     row_pos;
        int unsigned     lit_pixels;
        longint unsigned col_sum;
        int              first_row;
        int              last_row;
        bit              stopped;
        row_res_t        rows_due[$];
        int              errors;
        int              pixels_seen;
        int              rows_checked;
        int              lit_rows;
        int              stopped_rows;
        int              frames_ended;

        function new();
            cols_reg   = FRAME_COLS_RST;
            rows_reg   = FRAME_ROWS_RST;
            col_pos    = 0;
            row_pos    = 0;
            lit_pixels = 0;
            col_sum    = 0;
            first_row  = -1;
            last_row   = -1;
            stopped    = 1'b0;
        endfunction

        function int unsigned span_of(int unsigned v, int unsigned maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_FRAME_COLS: cols_reg = v;
                CFG_FRAME_ROWS: rows_reg = v;
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [7:0] p);
            int unsigned     cols;
            int unsigned     rows;
            longint unsigned quot;
            row_res_t        r;
            cols = span_of(cols_reg, MAX_COLS_DEF);
            rows = span_of(rows_reg, MAX_ROWS_DEF);
            pixels_seen++;
            if (!stopped && p == PIX_LIT)
            begin
                col_sum += col_pos;
                lit_pixels++;
            end
            if (col_pos + 1 < cols)
            begin
                col_pos++;
                return;
            end
            r = '0;
            if (!stopped)
            begin
                if (lit_pixels > 0)
                begin
                    quot = (col_sum << FRAC_BITS_DEF) / lit_pixels;
                    r.lit = 1'b1;
                    r.centroid = quot[CENT_W-1:0];
                    if (first_row == -1)
                        first_row = row_pos;
                    else
                        last_row = row_pos;
                end
                else if (last_row != -1)
                begin
                    stopped = 1'b1;
                end
            end
            r.row_index  = row_pos[ROW_W-1:0];
            r.stopped    = stopped;
            r.first_row  = first_row[EDGE_ROW_W-1:0];
            r.last_row   = last_row[EDGE_ROW_W-1:0];
            r.frame_done = (row_pos + 1 >= rows);
            rows_due = {rows_due, r};
            col_pos    = 0;
            col_sum    = 0;
            lit_pixels = 0;
            if (r.frame_done)
            begin
                row_pos   = 0;
                first_row = -1;
                last_row  = -1;
                stopped   = 1'b0;
            end
            else
            begin
                row_pos++;
            end
        endfunction

        function void report(string field, longint want, longint got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_row(row_res_t got);
            row_res_t want;
            if (rows_due.size() == 0)
            begin
                $display("%0t: unexpected row beat, row_index %0d", $time, got.row_index);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            rows_checked++;
            lit_rows     += want.lit;
            stopped_rows += want.stopped;
            frames_ended += want.frame_done;
            if (got.row_index !== want.row_index)
                report("row_index", want.row_index, got.row_index);
            if (got.centroid !== want.centroid)
                report("row_centroid", want.centroid, got.centroid);
            if (got.lit !== want.lit)
                report("row_lit", want.lit, got.lit);
            if (got.stopped !== want.stopped)
                report("scan_stopped", want.stopped, got.stopped);
            if (got.first_row !== want.first_row)
                report("first_lit_row", $signed(want.first_row), $signed(got.first_row));
            if (got.last_row !== want.last_row)
                report("last_lit_row", $signed(want.last_row), $signed(got.last_row));
            if (got.frame_done !== want.frame_done)
                report("frame_done", want.frame_done, got.frame_done);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rcs_pix_if pix();
    rcs_res_if res();
    rcs_cfg_if cfg();

    centroid_scoreboard sb;
    int gap_max;
    int stall_max;
    int hold_request;

    row_centroid_scanner i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    always #5 clk = ~clk;

    task automatic send_pixel(input logic [7:0] p);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= p;
        do @(posedge clk); while (!(pix.valid === 1'b1 && pix.ready === 1'b1));
        sb.take_pixel(p);
    endtask

    task automatic send_bytes(input byte_q_t bytes);
        foreach (bytes[i])
            send_pixel(bytes[i]);
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] cols,
                             input logic [CFG_DATA_W-1:0] rows);
        cfg.valid <= 1'b1;
        cfg.index <= CFG_FRAME_COLS;
        cfg.data  <= cols;
        do @(posedge clk); while (!(cfg.valid === 1'b1 && cfg.ready === 1'b1));
        sb.write_reg(CFG_FRAME_COLS, cols);
        cfg.index <= CFG_FRAME_ROWS;
        cfg.data  <= rows;
        do @(posedge clk); while (!(cfg.valid === 1'b1 && cfg.ready === 1'b1));
        sb.write_reg(CFG_FRAME_ROWS, rows);
        cfg.valid <= 1'b0;
    endtask

    task automatic finish_frame();
        while (sb.col_pos != 0 || sb.row_pos != 0)
            send_pixel(8'($urandom_range(0, 255)));
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin
        int n;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
            end
            else
            begin
                n = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
            end
            if (n > 0)
            begin
                res.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!(res.valid === 1'b1 && res.ready === 1'b1));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
            sb.check_row(row_res_t'{
                row_index:  res.row_index,
                centroid:   res.row_centroid,
                lit:        res.row_lit,
                stopped:    res.scan_stopped,
                first_row:  res.first_lit_row,
                last_row:   res.last_lit_row,
                frame_done: res.frame_done
            });
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        byte_q_t     bytes;
        int          random_pixels;
        int          phase;
        int          budget;
        int          phase_pixels;
        int unsigned cols_raw;
        int unsigned rows_raw;
        int unsigned cols_eff;
        int unsigned rows_eff;
        int          lead;
        int          run;
        int          spot;
        bit          noisy;
        row_kind_t   kind;
        logic [7:0]  b;

        sb = new();
        gap_max      = 0;
        stall_max    = 0;
        hold_request = 0;
        rst_n        = 1'b0;
        pix.valid    = 1'b0;
        pix.pixel    = 8'd0;
        cfg.valid    = 1'b0;
        cfg.index    = CFG_FRAME_COLS;
        cfg.data     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero lengths act as one pixel, one row
        set_frame(0, 0);
        bytes = '{8'hFF, 8'h00, 8'hFE};
        send_bytes(bytes);
        wait_drained();

        // lit, lit, empty: last row set, then stop on the frame's last row
        set_frame(4, 3);
        bytes = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00};
        send_bytes(bytes);
        wait_drained();

        // empty row before any lit row does not stop; lit pixels after a stop are dropped
        set_frame(2, 5);
        bytes = '{8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01,
                  8'hFF, 8'hFF};
        send_bytes(bytes);
        wait_drained();

        // shrink the row mid-row, then the frame mid-frame
        set_frame(6, 3);
        bytes = '{8'hFF, 8'hFF, 8'h00, 8'hFF};
        send_bytes(bytes);
        wait_drained();
        set_frame(2, 3);
        send_pixel(8'hFF);
        wait_drained();
        set_frame(2, 1);
        finish_frame();
        wait_drained();

        // oversized lengths clamp to the maximum; top centroid on a full-width row
        set_frame(2047, 2047);
        repeat (1023) send_pixel(8'($urandom_range(0, 254)));
        send_pixel(PIX_LIT);
        wait_drained();
        set_frame(2, 1);
        finish_frame();
        wait_drained();

        random_pixels = 0;
        phase = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            phase++;
            case ($urandom_range(0, 9))
                0:       cols_raw = 0;
                1, 2:    cols_raw = $urandom_range(13, 40);
                default: cols_raw = $urandom_range(1, 12);
            endcase
            if ($urandom_range(0, 9) == 0)
                rows_raw = 0;
            else
                rows_raw = $urandom_range(1, (cols_raw > 12) ? 4 : 12);
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 7;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_max = 0;
                1:       stall_max = 3;
                default: stall_max = 7;
            endcase
            budget = $urandom_range(40, 160);
            if (phase == 3)
            begin
                cols_raw     = 2;
                rows_raw     = 12;
                gap_max      = 0;
                stall_max    = 0;
                budget       = 300;
                hold_request = HOLD_CYCLES;
            end
            cols_eff = (cols_raw == 0) ? 1 : cols_raw;
            rows_eff = (rows_raw == 0) ? 1 : rows_raw;
            wait_drained();
            set_frame(CFG_DATA_W'(cols_raw), CFG_DATA_W'(rows_raw));

            phase_pixels = 0;
            while (phase_pixels < budget)
            begin
                noisy = ($urandom_range(0, 6) == 0);
                lead  = $urandom_range(0, rows_eff - 1);
                run   = $urandom_range(1, rows_eff);
                for (int r = 0; r < rows_eff; r++)
                begin
                    if (noisy)
                        kind = ROW_NOISE;
                    else if (r < lead)
                        kind = ROW_EMPTY;
                    else if (r < lead + run || $urandom_range(0, 1) == 1)
                        kind = row_kind_t'($urandom_range(ROW_FULL, ROW_SINGLE));
                    else
                        kind = ROW_EMPTY;
                    spot = $urandom_range(0, cols_eff - 1);
                    for (int c = 0; c < cols_eff; c++)
                    begin
                        case (kind)
                            ROW_EMPTY:  b = 8'($urandom_range(0, 254));
                            ROW_FULL:   b = PIX_LIT;
                            ROW_SPARSE: b = ($urandom_range(0, 2) == 0) ?
                                            PIX_LIT : 8'($urandom_range(0, 254));
                            ROW_SINGLE: b = (c == spot) ?
                                            PIX_LIT : 8'($urandom_range(0, 254));
                            default:    b = ($urandom_range(0, 1) == 1) ?
                                            PIX_LIT : 8'($urandom_range(0, 255));
                        endcase
                        if ($urandom_range(0, 299) == 0)
                            wait_drained();
                        send_pixel(b);
                        phase_pixels++;
                    end
                end
            end
            random_pixels += phase_pixels;
        end

        wait_drained();
        $display("tb: %0d pixels sent, %0d row beats checked (%0d lit, %0d stopped), %0d frames",
                 sb.pixels_seen, sb.rows_checked, sb.lit_rows, sb.stopped_rows,
                 sb.frames_ended);
        $display("tb: %0d random phases, frame lengths 0 to 2047 incl. mid-row changes",
                 phase);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
